// ----- sv/assert_macros.svh -----
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- sv/cpd_pkg.sv -----
// Types, constants and the CRC-8 function of the packet deframer.
package cpd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] HEADER_RESET = 8'h00;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd128;
   localparam int unsigned PADDR_WIDTH = 3;
   localparam logic [PADDR_WIDTH-1:0] ADDR_HEADER_BYTE = 3'd0;
   localparam logic [PADDR_WIDTH-1:0] ADDR_MAX_LENGTH = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_CRC  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_CRC_BAD  = 2'd2,
      KIND_TOO_LONG = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] header_byte;
      logic [7:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_length;
   } result_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ----- sv/cpd_if.sv -----
// Word channels of the packet deframer: received bytes in, results out.
interface cpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [7:0] frame_length;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output frame_length, input ready);
   modport sink (input valid, input kind, input data_byte, input byte_index,
                 input frame_length, output ready);
endinterface

// ----- sv/cpd_csr.sv -----
// Configuration registers of the packet deframer behind an APB-style port.
module cpd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cpd_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output cpd_pkg::cfg_type                cfg
);
   import cpd_pkg::*;

   logic [7:0] header_byte_ff;
   logic [7:0] header_byte_in;
   logic [7:0] max_length_ff;
   logic [7:0] max_length_in;
   logic       write_en;

   assign pready = 1'b1;
   assign write_en = psel && penable && pwrite && pready;

   always_comb begin
      header_byte_in = header_byte_ff;
      max_length_in = max_length_ff;
      if (write_en) begin
         unique case (paddr[2])
            ADDR_HEADER_BYTE[2]: header_byte_in = pwdata[7:0];
            default:             max_length_in = pwdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= HEADER_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         header_byte_ff <= header_byte_in;
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         ADDR_MAX_LENGTH[2]: prdata = {24'd0, max_length_ff};
         default:            prdata = {24'd0, header_byte_ff};
      endcase
   end

   assign cfg.header_byte = header_byte_ff;
   assign cfg.max_length = max_length_ff;
endmodule

// ----- sv/cpd_parser.sv -----
// Frame state machine: phase, remaining count, running CRC and the result of one byte.
module cpd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          rx_byte,
   input  cpd_pkg::cfg_type    cfg,
   output cpd_pkg::result_type result
);
   import cpd_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] remaining_ff;
   logic [7:0] remaining_in;
   logic [7:0] crc_ff;
   logic [7:0] crc_in;
   logic [7:0] declared_ff;
   logic [7:0] declared_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         remaining_ff <= 8'd0;
         crc_ff <= 8'd0;
         declared_ff <= 8'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         remaining_ff <= remaining_in;
         crc_ff <= crc_in;
         declared_ff <= declared_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      remaining_in = remaining_ff;
      crc_in = crc_ff;
      declared_in = declared_ff;
      result.valid = 1'b0;
      result.kind = KIND_PAYLOAD;
      result.data_byte = rx_byte;
      result.byte_index = 8'd0;
      result.frame_length = declared_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == cfg.header_byte) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (rx_byte > cfg.max_length) begin
               phase_in = PH_HUNT;
               result.valid = 1'b1;
               result.kind = KIND_TOO_LONG;
               result.frame_length = rx_byte;
            end else begin
               declared_in = rx_byte;
               remaining_in = rx_byte;
               crc_in = 8'd0;
               phase_in = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
            end
         end
         PH_DATA: begin
            result.valid = 1'b1;
            result.byte_index = declared_ff - remaining_ff;
            crc_in = crc8_update(crc_ff, rx_byte);
            remaining_in = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            result.valid = 1'b1;
            result.kind = (rx_byte == crc_ff) ? KIND_GOOD : KIND_CRC_BAD;
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end
endmodule

// ----- sv/crc8_packet_deframer.sv -----
// Top level of the CRC-8 length-prefixed packet deframer.
// Received bytes enter on req_chan, one word per valid/ready handshake.
// Each byte is captured in an input register; once the output register is free
// or read, the frame state machine decides its meaning and any result is loaded
// into the output register that drives rsp_chan. A frame is a header byte, a
// length byte, the payload and a CRC-8 byte (polynomial 0x07, initial value 0).
// Payload bytes come out with their index; the CRC byte gives good or bad;
// a length above max_length gives a length error and the parser hunts again.
// Header bytes, accepted lengths and skipped bytes produce no result word.
// Each byte passes the input register and its result the output register on
// the way to rsp_chan valid, and one byte is accepted every cycle as long as
// the receiver takes results.
// When the receiver stalls, the output register holds its word and the input
// register holds one more byte; ready drops only while both are full.
// Synchronous reset returns the parser to hunting, clears both registers and sets
// header_byte to 0 and max_length to 128. The registers at byte addresses 0 and 4
// are written by the user over the APB port while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"
module crc8_packet_deframer (
   input  logic                            clock,
   input  logic                            reset,
   cpd_req_if.sink                         req_chan,
   cpd_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cpd_pkg::PADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import cpd_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_word_ff;
   logic       advance;
   logic       req_fire;

   cpd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cpd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = result.valid;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.kind = out_word_ff.kind;
   assign rsp_chan.data_byte = out_word_ff.data_byte;
   assign rsp_chan.byte_index = out_word_ff.byte_index;
   assign rsp_chan.frame_length = out_word_ff.frame_length;

   `ASSERT_IMPLIES(a_payload_index, clock, reset,
      out_valid_ff && out_word_ff.kind == KIND_PAYLOAD,
      out_word_ff.byte_index < out_word_ff.frame_length, "payload index beyond length")
   `ASSERT_IMPLIES(a_too_long_word, clock, reset,
      out_valid_ff && out_word_ff.kind == KIND_TOO_LONG,
      out_word_ff.byte_index == 8'd0 && out_word_ff.data_byte == out_word_ff.frame_length,
      "length error word malformed")
   `ASSERT_IMPLIES(a_ready_low_when_full, clock, reset,
      !req_chan.ready, in_valid_ff && out_valid_ff && !rsp_chan.ready,
      "input stalled without a full pipeline")
   `ASSERT_NEXT(a_held_byte, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff),
      "held input byte lost")
endmodule
